// ===== rtl/core/rfo_pkg.sv =====
package rfo_pkg;

    localparam int unsigned NUM_W = 64;
    localparam int unsigned DEN_W = 63;

    typedef enum logic [1:0] {
        KIND_ADD = 2'd0,
        KIND_SUB = 2'd1,
        KIND_MUL = 2'd2,
        KIND_DIV = 2'd3
    } t_kind;

    typedef struct packed {
        logic load;
        logic prod;
        logic combine;
        logic gcd_start;
        logic div_start;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic inf;
        logic gcd_done;
        logic div_done;
    } t_status;

endpackage

// ===== rtl/core/rfo_if.sv =====
interface rfo_in_if #(
    parameter int OPERAND_WIDTH = 32
);
    logic                        valid;
    logic                        ready;
    logic [1:0]                  kind;
    logic [OPERAND_WIDTH-1:0]    lhs_num;
    logic [OPERAND_WIDTH-2:0]    lhs_den;
    logic [OPERAND_WIDTH-1:0]    rhs_num;
    logic [OPERAND_WIDTH-2:0]    rhs_den;
    modport source (output valid, kind, lhs_num, lhs_den, rhs_num, rhs_den, input ready);
    modport sink (input valid, kind, lhs_num, lhs_den, rhs_num, rhs_den, output ready);
endinterface

interface rfo_out_if;
    logic                        valid;
    logic                        ready;
    logic [rfo_pkg::NUM_W-1:0]   result_num;
    logic [rfo_pkg::DEN_W-1:0]   result_den;
    logic                        is_inf;
    modport source (output valid, result_num, result_den, is_inf, input ready);
    modport sink (input valid, result_num, result_den, is_inf, output ready);
endinterface

// ===== rtl/core/rational_four_op_unit.sv =====
// Sequence: load, products, combine, then the Euclid steps and the two final
// divisions, all done by one bit-serial 64-bit divider; infinite results do not wait for the divider.
// Throughput: one transaction at a time; the next is accepted after the result is taken.
// Reset: synchronous, active low; clears the controller and drops the output valid.
module rational_four_op_unit #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rfo_in_if.sink   i_in,
    rfo_out_if.source o_out
);
    rfo_pkg::t_cmd    cmd;
    rfo_pkg::t_status status;

    rfo_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in.valid),
        .o_ready  (i_in.ready),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    rfo_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
        .i_clk        (i_clk),
        .i_cmd        (cmd),
        .i_kind       (i_in.kind),
        .i_lhs_num    (i_in.lhs_num),
        .i_lhs_den    (i_in.lhs_den),
        .i_rhs_num    (i_in.rhs_num),
        .i_rhs_den    (i_in.rhs_den),
        .o_status     (status),
        .o_result_num (o_out.result_num),
        .o_result_den (o_out.result_den),
        .o_is_inf     (o_out.is_inf)
    );
endmodule

// ===== rtl/core/rfo_datapath.sv =====
module rfo_datapath #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                        i_clk,
    input  rfo_pkg::t_cmd               i_cmd,
    input  logic [1:0]                  i_kind,
    input  logic [OPERAND_WIDTH-1:0]    i_lhs_num,
    input  logic [OPERAND_WIDTH-2:0]    i_lhs_den,
    input  logic [OPERAND_WIDTH-1:0]    i_rhs_num,
    input  logic [OPERAND_WIDTH-2:0]    i_rhs_den,
    output rfo_pkg::t_status            o_status,
    output logic [rfo_pkg::NUM_W-1:0]   o_result_num,
    output logic [rfo_pkg::DEN_W-1:0]   o_result_den,
    output logic                        o_is_inf
);
    localparam int W = 64;
    localparam int DEN_W_L = rfo_pkg::DEN_W;

    logic [1:0]                        r_kind;
    logic signed [OPERAND_WIDTH-1:0]   r_ln, r_ld, r_rn, r_rd;
    logic signed [W-1:0]               r_p0, r_p1, r_p2;
    logic                              r_neg, r_inf;
    logic [W-1:0]                      r_x, r_y, r_mt, r_mb, r_g;
    logic [W-1:0]                      r_rem, r_quo, r_div;
    logic [6:0]                        r_cnt;
    logic                              r_gbusy, r_rbusy, r_dsel, r_dbusy;
    logic [W-1:0]                      r_qt;
    logic [W-1:0]                      r_out_num;
    logic [DEN_W_L-1:0]                r_out_den;

    logic signed [W-1:0]               top, bot;
    logic [W:0]                        trial;
    logic [W-1:0]                      rem_sh;
    logic signed [OPERAND_WIDTH-1:0]   mul_b0, mul_b2;
    logic signed [2*OPERAND_WIDTH-1:0] prod0, prod1, prod2;

    always_comb begin
        mul_b0 = r_rd;
        mul_b2 = r_rd;
        case (r_kind)
            rfo_pkg::KIND_MUL: mul_b0 = r_rn;
            rfo_pkg::KIND_DIV: mul_b2 = r_rn;
            default: ;
        endcase
    end

    assign prod0 = r_ln * mul_b0;
    assign prod1 = r_ld * r_rn;
    assign prod2 = r_ld * mul_b2;

    always_comb begin
        top = '0;
        bot = r_p2;
        case (r_kind)
            rfo_pkg::KIND_ADD: top = r_p0 + r_p1;
            rfo_pkg::KIND_SUB: top = r_p0 - r_p1;
            rfo_pkg::KIND_MUL: top = r_p0;
            default: begin
                top = r_p0;
                if (r_p2 < 0) begin
                    top = -r_p0;
                    bot = -r_p2;
                end
            end
        endcase
    end

    // One restoring-division step per cycle, shared by the remainder and quotient phases.
    assign rem_sh = {r_rem[W-2:0], r_quo[W-1]};
    assign trial  = {1'b0, rem_sh} - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_ln   <= signed'(i_lhs_num);
            r_rn   <= signed'(i_rhs_num);
            r_ld   <= signed'({1'b0, i_lhs_den});
            r_rd   <= signed'({1'b0, i_rhs_den});
            r_inf  <= (i_lhs_den == '0) || (i_rhs_den == '0) ||
                      ((i_kind == rfo_pkg::KIND_DIV) && (i_rhs_num == '0));
        end
        if (i_cmd.prod) begin
            r_p0 <= W'(prod0);
            r_p2 <= W'(prod2);
            case (r_kind)
                rfo_pkg::KIND_MUL, rfo_pkg::KIND_DIV: r_p1 <= '0;
                default: r_p1 <= W'(prod1);
            endcase
        end
        if (i_cmd.combine) begin
            r_inf <= r_inf || (bot <= 0);
            r_neg <= top < 0;
            r_mt  <= top < 0 ? -top : top;
            r_mb  <= bot;
        end
        if (i_cmd.gcd_start) begin
            r_x     <= r_mt;
            r_y     <= r_mb;
            r_gbusy <= 1'b1;
            r_rbusy <= 1'b0;
        end else if (i_cmd.div_start) begin
            r_dsel  <= 1'b0;
            r_dbusy <= 1'b1;
            r_g     <= r_x;
            r_quo   <= r_mt;
            r_div   <= r_x;
            r_rem   <= '0;
            r_cnt   <= '0;
        end else if (r_gbusy) begin
            if (!r_rbusy) begin
                if (r_y == '0) begin
                    r_gbusy <= 1'b0;
                end else begin
                    r_rbusy <= 1'b1;
                    r_quo   <= r_x;
                    r_div   <= r_y;
                    r_rem   <= '0;
                    r_cnt   <= '0;
                end
            end else begin
                r_rem <= trial[W] ? rem_sh : trial[W-1:0];
                r_quo <= {r_quo[W-2:0], ~trial[W]};
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'(W-1)) begin
                    r_rbusy <= 1'b0;
                    r_x     <= r_y;
                    r_y     <= trial[W] ? rem_sh : trial[W-1:0];
                end
            end
        end else if (r_dbusy) begin
            r_rem <= trial[W] ? rem_sh : trial[W-1:0];
            r_quo <= {r_quo[W-2:0], ~trial[W]};
            r_cnt <= r_cnt + 7'd1;
            if (r_cnt == 7'(W-1)) begin
                r_cnt <= '0;
                r_rem <= '0;
                if (!r_dsel) begin
                    r_qt   <= {r_quo[W-2:0], ~trial[W]};
                    r_quo  <= r_mb;
                    r_dsel <= 1'b1;
                end else begin
                    r_dbusy <= 1'b0;
                end
            end
        end
        if (i_cmd.finish) begin
            r_out_num <= r_inf ? '0 : (r_neg ? -r_qt : r_qt);
            r_out_den <= r_inf ? '0 : r_quo[DEN_W_L-1:0];
        end
        if (i_cmd.load) begin
            r_gbusy <= 1'b0;
            r_dbusy <= 1'b0;
        end
    end

    assign o_status.inf      = r_inf;
    assign o_status.gcd_done = !r_gbusy;
    assign o_status.div_done = !r_dbusy;
    assign o_result_num      = r_out_num;
    assign o_result_den      = r_out_den;
    assign o_is_inf          = r_inf;
endmodule

// ===== rtl/core/rfo_ctrl.sv =====
module rfo_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    output logic               o_valid,
    input  logic               i_ready,
    input  rfo_pkg::t_status   i_status,
    output rfo_pkg::t_cmd      o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_PROD, S_COMB, S_GCD, S_WGCD, S_WDIV, S_FIN, S_OUT
    } t_state;

    t_state r_state;
    logic   r_valid;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;

    always_comb begin
        o_cmd           = '0;
        o_cmd.load      = (r_state == S_IDLE) && i_valid;
        o_cmd.prod      = (r_state == S_PROD);
        o_cmd.combine   = (r_state == S_COMB);
        o_cmd.gcd_start = (r_state == S_GCD);
        o_cmd.div_start = (r_state == S_WGCD) && i_status.gcd_done;
        o_cmd.finish    = (r_state == S_FIN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: if (i_valid) r_state <= S_PROD;
                S_PROD: r_state <= S_COMB;
                S_COMB: r_state <= S_GCD;
                S_GCD: r_state <= i_status.inf ? S_FIN : S_WGCD;
                S_WGCD: if (i_status.gcd_done) r_state <= S_WDIV;
                S_WDIV: if (i_status.div_done) r_state <= S_FIN;
                S_FIN: begin
                    r_state <= S_OUT;
                    r_valid <= 1'b1;
                end
                S_OUT: if (i_ready) begin
                    r_state <= S_IDLE;
                    r_valid <= 1'b0;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== dv/tb_rational_four_op_unit.sv =====
`timescale 1ns / 100ps

module tb_rational_four_op_unit;

    localparam int OPW = 32;
    localparam int RANDOM_ITEMS = 800;
    localparam longint CYCLE_LIMIT = 40_000_000;

    typedef struct {
        logic [rfo_pkg::NUM_W-1:0] num;
        logic [rfo_pkg::DEN_W-1:0] den;
        logic                      inf;
    } t_fraction;

    class fraction_scoreboard;
        t_fraction pending_q[$];
        int        n_errors;
        int        n_checked;
        int        n_inf;

        function new();
            n_errors  = 0;
            n_checked = 0;
            n_inf     = 0;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            n_errors++;
        endtask

        function void note(rfo_pkg::t_kind k, logic [OPW-1:0] a_num, logic [OPW-2:0] a_den,
                           logic [OPW-1:0] b_num, logic [OPW-2:0] b_den);
            longint            ln;
            longint            ld;
            longint            rn;
            longint            rd;
            longint            top;
            longint            bot;
            longint unsigned   mt;
            longint unsigned   mb;
            longint unsigned   x;
            longint unsigned   y;
            longint unsigned   t;
            logic              inf;
            t_fraction         e;
            ln  = longint'($signed(a_num));
            rn  = longint'($signed(b_num));
            ld  = longint'({1'b0, a_den});
            rd  = longint'({1'b0, b_den});
            inf = (ld == 0) || (rd == 0);
            case (k)
                rfo_pkg::KIND_ADD: begin
                    top = ln * rd + ld * rn;
                    bot = ld * rd;
                end
                rfo_pkg::KIND_SUB: begin
                    top = ln * rd - ld * rn;
                    bot = ld * rd;
                end
                rfo_pkg::KIND_MUL: begin
                    top = ln * rn;
                    bot = ld * rd;
                end
                default: begin
                    top = ln * rd;
                    bot = ld * rn;
                    if (rn == 0) inf = 1'b1;
                    if (bot < 0) begin
                        top = -top;
                        bot = -bot;
                    end
                end
            endcase
            if (inf || bot <= 0) begin
                e.num = '0;
                e.den = '0;
                e.inf = 1'b1;
            end else begin
                mt = (top < 0) ? longint'(0) - top : top;
                mb = bot;
                x  = mt;
                y  = mb;
                while (y != 0) begin
                    t = x % y;
                    x = y;
                    y = t;
                end
                mt    = mt / x;
                mb    = mb / x;
                e.num = (top < 0) ? 64'd0 - mt : mt;
                e.den = mb[rfo_pkg::DEN_W-1:0];
                e.inf = 1'b0;
            end
            pending_q.push_back(e);
        endfunction

        task check(logic [rfo_pkg::NUM_W-1:0] num, logic [rfo_pkg::DEN_W-1:0] den, logic inf);
            t_fraction e;
            if (pending_q.size() == 0) begin
                report("result transaction with nothing pending");
                return;
            end
            e = pending_q.pop_front();
            n_checked++;
            if (e.inf) n_inf++;
            if (num !== e.num)
                report($sformatf("result_num %0d, expected %0d", $signed(num), $signed(e.num)));
            if (den !== e.den)
                report($sformatf("result_den %0d, expected %0d", den, e.den));
            if (inf !== e.inf)
                report($sformatf("is_inf %0b, expected %0b", inf, e.inf));
        endtask
    endclass

    logic   i_clk;
    logic   i_rst_n;
    bit     quiet;
    int     stall_left;
    longint n_cycles;
    int     n_sent;

    fraction_scoreboard sb;

    rfo_in_if #(.OPERAND_WIDTH(OPW)) in_if ();
    rfo_out_if out_if ();

    rational_four_op_unit #(.OPERAND_WIDTH(OPW)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.kind      = '0;
        in_if.lhs_num   = '0;
        in_if.lhs_den   = '0;
        in_if.rhs_num   = '0;
        in_if.rhs_den   = '0;
        out_if.ready    = 1'b0;
        quiet           = 1'b0;
        stall_left      = 0;
        n_cycles        = 0;
        n_sent          = 0;
        sb              = new();
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", n_cycles);
            $display("tb_rational_four_op_unit: errors");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            out_if.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            out_if.ready <= 1'b0;
            stall_left   <= $urandom_range(0, 3);
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check(out_if.result_num, out_if.result_den, out_if.is_inf);
    end

    task automatic send(rfo_pkg::t_kind k, logic [OPW-1:0] a_num, logic [OPW-2:0] a_den,
                        logic [OPW-1:0] b_num, logic [OPW-2:0] b_den);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.kind    <= k;
        in_if.lhs_num <= a_num;
        in_if.lhs_den <= a_den;
        in_if.rhs_num <= b_num;
        in_if.rhs_den <= b_den;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note(k, a_num, a_den, b_num, b_den);
        n_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [OPW-1:0] pick_num();
        case ($urandom_range(0, 5))
            0, 1, 2: return $urandom();
            3:       return OPW'($signed($urandom_range(0, 40)) - 20);
            4:       return {1'b1, {(OPW-1){1'b0}}} + OPW'($urandom_range(0, 3));
            default: return {1'b0, {(OPW-1){1'b1}}} - OPW'($urandom_range(0, 3));
        endcase
    endfunction

    function automatic logic [OPW-2:0] pick_den();
        case ($urandom_range(0, 39))
            0:                              return '0;
            1, 2, 3:                        return '1;
            4, 5, 6, 7, 8, 9, 10, 11, 12:   return (OPW-1)'($urandom_range(1, 30));
            default:                        return (OPW-1)'($urandom());
        endcase
    endfunction

    localparam logic [OPW-1:0] NMIN = {1'b1, {(OPW-1){1'b0}}};
    localparam logic [OPW-1:0] NMAX = {1'b0, {(OPW-1){1'b1}}};
    localparam logic [OPW-2:0] DMAX = '1;

    initial begin
        rfo_pkg::t_kind k;
        int             i;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send(rfo_pkg::KIND_ADD, 32'd1, 31'd2, 32'd1, 31'd3);
        send(rfo_pkg::KIND_SUB, 32'd5, 31'd7, 32'd5, 31'd7);
        send(rfo_pkg::KIND_MUL, -32'sd3, 31'd4, 32'd8, 31'd9);
        send(rfo_pkg::KIND_DIV, 32'd1, 31'd2, -32'sd1, 31'd3);
        send(rfo_pkg::KIND_DIV, 32'd5, 31'd3, 32'd0, 31'd7);
        send(rfo_pkg::KIND_DIV, 32'd0, 31'd1, 32'd0, 31'd1);
        send(rfo_pkg::KIND_ADD, 32'd3, 31'd0, 32'd1, 31'd2);
        send(rfo_pkg::KIND_MUL, 32'd3, 31'd5, 32'd1, 31'd0);
        send(rfo_pkg::KIND_DIV, 32'd0, 31'd0, 32'd0, 31'd0);
        send(rfo_pkg::KIND_MUL, NMIN, 31'd1, NMIN, 31'd1);
        send(rfo_pkg::KIND_DIV, NMAX, 31'd1, NMIN, 31'd1);
        send(rfo_pkg::KIND_ADD, NMAX, DMAX, NMAX, DMAX);
        send(rfo_pkg::KIND_ADD, NMIN, DMAX, NMIN, DMAX - 31'd1);
        send(rfo_pkg::KIND_SUB, NMIN, DMAX, NMAX, DMAX - 31'd1);
        send(rfo_pkg::KIND_SUB, NMAX, 31'd1, NMIN, 31'd1);
        send(rfo_pkg::KIND_MUL, 32'd6, 31'd3, 32'd1, 31'd1);
        send(rfo_pkg::KIND_DIV, NMIN, DMAX, NMIN, DMAX);
        send(rfo_pkg::KIND_DIV, 32'hFFFF_FFFF, 31'd1, NMIN, DMAX);
        send(rfo_pkg::KIND_MUL, 32'd0, DMAX, NMIN, 31'd1);
        send(rfo_pkg::KIND_ADD, 32'hAAAA_AAAA, 31'h5555_5555, 32'h5555_5555, 31'h2AAA_AAAA);

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS - 100) quiet = 1'b1;
            k = rfo_pkg::t_kind'($urandom_range(0, 3));
            send(k, pick_num(), pick_den(), pick_num(), pick_den());
        end
        in_if.valid <= 1'b0;

        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("sent %0d operations, checked %0d results, %0d of them infinite",
                 n_sent, sb.n_checked, sb.n_inf);
        if (sb.n_errors == 0) begin
            $display("tb_rational_four_op_unit: clean");
        end else begin
            $display("%0d mismatches", sb.n_errors);
            $display("tb_rational_four_op_unit: errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/rfo_pkg.sv
rtl/core/rfo_if.sv
rtl/core/rfo_datapath.sv
rtl/core/rfo_ctrl.sv
rtl/core/rational_four_op_unit.sv
dv/tb_rational_four_op_unit.sv
